// ----- sv/e2q_pkg.sv -----
// shared constants and tables for the euler to quaternion core
`default_nettype none
package e2q_pkg;
   localparam int CordicSteps = 30;
   localparam int FracBits    = 30;
   localparam int XyBits      = 34;
   localparam int ZBits       = 34;
   localparam int TrigBits    = 32;
   localparam logic signed [XyBits-1:0] CordicGain = 34'sd652032874;

   typedef logic signed [TrigBits-1:0] trig_type;

   typedef struct packed {
      trig_type sn;
      trig_type cs;
   } sincos_type;

   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] r;
      begin
         case (idx)
            0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
            3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
            6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
            9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
            12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
            15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
            18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
            21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
            24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
            27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

// ----- sv/euler_to_quaternion_core.sv -----
// euler angles (zyx) to quaternion core, three cordic lanes and a merge pipeline
//  channel | dir | tdata (low bit up)                        | tuser/tlast
//  req     | in  | roll_angle, pitch_angle, yaw_angle        | none
//  rsp     | out | quat_x, quat_y, quat_z, quat_w            | none
// one request per cycle while rsp is not stalled (31 cordic stages plus 3 merge stages)
// the whole pipeline holds while a result waits on rsp_tready
// reset (synchronous) clears the valid pipeline only
`default_nettype none
module euler_to_quaternion_core #(
   parameter int ANGLE_BITS = 16,
   parameter int COMPONENT_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   input  wire logic [((3*ANGLE_BITS+7)/8)*8-1:0] req_tdata, // roll, pitch, yaw
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [((4*COMPONENT_BITS+7)/8)*8-1:0] rsp_tdata // x, y, z, w
);
   localparam int Latency = e2q_pkg::CordicSteps + 4;
   localparam int OutW = ((4*COMPONENT_BITS+7)/8)*8;

   logic [Latency-1:0] valid_ff;
   logic [Latency-1:0] valid_in;
   logic enable;
   e2q_pkg::sincos_type roll_sc, pitch_sc, yaw_sc;
   logic [4*COMPONENT_BITS-1:0] quat;

   assign enable = !valid_ff[Latency-1] || rsp_tready;
   assign req_tready = enable;
   assign valid_in = {valid_ff[Latency-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (enable) valid_ff <= valid_in;
   end

   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
      .clock(clock), .enable(enable),
      .angle(req_tdata[ANGLE_BITS-1:0]), .result(roll_sc));
   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
      .clock(clock), .enable(enable),
      .angle(req_tdata[2*ANGLE_BITS-1:ANGLE_BITS]), .result(pitch_sc));
   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
      .clock(clock), .enable(enable),
      .angle(req_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]), .result(yaw_sc));

   e2q_merge #(.COMPONENT_BITS(COMPONENT_BITS)) u_merge (
      .clock(clock), .enable(enable),
      .roll(roll_sc), .pitch(pitch_sc), .yaw(yaw_sc), .quat(quat));

   assign rsp_tvalid = valid_ff[Latency-1];
   assign rsp_tdata = OutW'(quat);

`ifndef SYNTH
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output stall");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (req_tready && !valid_ff[Latency-2]) |=> !rsp_tvalid)
      else $error("result appeared from an empty stage");
`endif
endmodule
`default_nettype wire

// ----- sv/e2q_cordic.sv -----
// pipelined rotation cordic lane: sine and cosine of half an angle
`default_nettype none
module e2q_cordic #(
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   enable,
   input  wire logic [ANGLE_BITS-1:0]  angle,
   output e2q_pkg::sincos_type         result
);
   localparam int Steps = e2q_pkg::CordicSteps;
   localparam int Xw = e2q_pkg::XyBits;
   localparam int Zw = e2q_pkg::ZBits;

   logic signed [Xw-1:0] x_ff [0:Steps];
   logic signed [Xw-1:0] y_ff [0:Steps];
   logic signed [Zw-1:0] z_ff [0:Steps];
   logic signed [Zw-1:0] z_in;

   assign z_in = (Zw'($signed(angle)) <<< (32 - ANGLE_BITS)) >>> 1;

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0] <= e2q_pkg::CordicGain;
         y_ff[0] <= '0;
         z_ff[0] <= z_in;
      end
   end

   for (genvar i = 0; i < Steps; i++) begin : g_step
      localparam logic signed [Zw-1:0] Atan = Zw'(e2q_pkg::atan_turn(i));
      logic signed [Xw-1:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!z_ff[i][Zw-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - Atan;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + Atan;
            end
         end
      end
   end

   assign result = '{sn: y_ff[Steps][e2q_pkg::TrigBits-1:0],
                     cs: x_ff[Steps][e2q_pkg::TrigBits-1:0]};
endmodule
`default_nettype wire

// ----- sv/e2q_merge.sv -----
// product, sum, rounding (or scaling) and saturation stages combining the three lanes
`default_nettype none
module e2q_merge #(
   parameter int COMPONENT_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       enable,
   input  wire e2q_pkg::sincos_type        roll,
   input  wire e2q_pkg::sincos_type        pitch,
   input  wire e2q_pkg::sincos_type        yaw,
   output logic [4*COMPONENT_BITS-1:0]     quat
);
   localparam int Tw = e2q_pkg::TrigBits;
   localparam int Fb = e2q_pkg::FracBits;
   localparam int Of = COMPONENT_BITS - 1;
   localparam int Sw = Tw + 3;

   logic signed [Tw-1:0] pair_ff [0:3];
   logic signed [Tw-1:0] sr_ff, cr_ff;
   logic signed [Tw-1:0] tri_ff [0:7];
   logic signed [2*Tw-1:0] pair_in [0:3];
   logic signed [2*Tw-1:0] tri_in [0:7];
   logic signed [Sw-1:0] sum [0:3];
   logic [4*COMPONENT_BITS-1:0] quat_ff;

   // pairs: cy*cp, sy*sp, cy*sp, sy*cp
   assign pair_in[0] = yaw.cs * pitch.cs;
   assign pair_in[1] = yaw.sn * pitch.sn;
   assign pair_in[2] = yaw.cs * pitch.sn;
   assign pair_in[3] = yaw.sn * pitch.cs;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 4; k++) pair_ff[k] <= pair_in[k][Fb+Tw-1:Fb];
         sr_ff <= roll.sn;
         cr_ff <= roll.cs;
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_tri
      assign tri_in[2*k]   = pair_ff[k] * sr_ff;
      assign tri_in[2*k+1] = pair_ff[k] * cr_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 8; k++) tri_ff[k] <= tri_in[k][Fb+Tw-1:Fb];
      end
   end

   // tri index: 0 cycp*sr 1 cycp*cr 2 sysp*sr 3 sysp*cr 4 cysp*sr 5 cysp*cr 6 sycp*sr 7 sycp*cr
   assign sum[0] = Sw'(tri_ff[0]) - Sw'(tri_ff[3]);
   assign sum[1] = Sw'(tri_ff[5]) + Sw'(tri_ff[6]);
   assign sum[2] = Sw'(tri_ff[7]) - Sw'(tri_ff[4]);
   assign sum[3] = Sw'(tri_ff[1]) + Sw'(tri_ff[2]);

   for (genvar k = 0; k < 4; k++) begin : g_out
      localparam int Rw = Sw + 2 + ((Of > Fb) ? (Of - Fb) : 0);
      localparam logic signed [Rw-1:0] Hi = Rw'((64'sd1 <<< Of) - 1);
      localparam logic signed [Rw-1:0] Lo = -Rw'(64'sd1 <<< Of);
      logic signed [Rw-1:0] r;
      logic [COMPONENT_BITS-1:0] q;
      if (Of <= Fb) begin : g_round
         localparam int Sh = Fb - Of;
         localparam logic signed [Rw-1:0] Half = (Sh > 0) ? Rw'(64'sd1 <<< (Sh - 1)) : '0;
         assign r = (Rw'(sum[k]) + Half) >>> Sh;
      end else begin : g_scale
         assign r = Rw'(sum[k]) <<< (Of - Fb);
      end
      always_comb begin
         if (r > Hi) q = Hi[COMPONENT_BITS-1:0];
         else if (r < Lo) q = Lo[COMPONENT_BITS-1:0];
         else q = r[COMPONENT_BITS-1:0];
      end
      always_ff @(posedge clock) begin
         if (enable) quat_ff[k*COMPONENT_BITS +: COMPONENT_BITS] <= q;
      end
   end

   assign quat = quat_ff;
endmodule
`default_nettype wire
